// File: rtl/core/isingm_pkg.sv
// Shared types, constants and index helpers for the Ising Metropolis spin update block.
package isingm_pkg;

    localparam int unsigned LATTICE_SIDE = 64;
    localparam int unsigned IDX_W        = $clog2(LATTICE_SIDE);
    localparam int unsigned FIELD_W      = 6;
    localparam int unsigned THRESH_W     = 32;
    localparam int unsigned ENERGY_W     = 5;

    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [LATTICE_SIDE-1:0] t_row;
    typedef logic [THRESH_W-1:0]     t_thresh;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2
    } t_command;

    localparam logic CFG_ACCEPT_FOUR  = 1'b0;
    localparam logic CFG_ACCEPT_EIGHT = 1'b1;

    // Row read request: one row address per memory copy.
    typedef struct packed {
        logic en;
        t_idx up;
        t_idx here;
        t_idx down;
    } t_read_req;

    // Full-row write, applied to every memory copy.
    typedef struct packed {
        logic en;
        t_idx row;
        t_row data;
    } t_write_req;

    function automatic t_idx reduce_index(input logic [FIELD_W-1:0] v);
        return t_idx'(v % LATTICE_SIDE);
    endfunction

    function automatic t_idx wrap_dec(input t_idx v);
        return (v == t_idx'(0)) ? t_idx'(LATTICE_SIDE - 1) : v - t_idx'(1);
    endfunction

    function automatic t_idx wrap_inc(input t_idx v);
        return (v == t_idx'(LATTICE_SIDE - 1)) ? t_idx'(0) : v + t_idx'(1);
    endfunction

endpackage

// File: rtl/core/isingm_if.sv
// Valid/ready channel interfaces for the item input and the result output.
interface isingm_item_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        command;
    logic [isingm_pkg::FIELD_W-1:0]    row;
    logic [isingm_pkg::FIELD_W-1:0]    column;
    logic [isingm_pkg::THRESH_W-1:0]   random_fraction;
    logic                              spin_value;

    modport source (output valid, command, row, column, random_fraction, spin_value,
                    input ready);
    modport sink   (input valid, command, row, column, random_fraction, spin_value,
                    output ready);
endinterface

interface isingm_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 spin_after;
    logic                                 flipped;
    logic signed [isingm_pkg::ENERGY_W-1:0] energy_change;

    modport source (output valid, spin_after, flipped, energy_change, input ready);
    modport sink   (input valid, spin_after, flipped, energy_change, output ready);
endinterface

// File: rtl/core/isingm_lattice.sv
// Spin lattice: three row-wide memory copies, per-row valid bits and a write-back bypass.
module isingm_lattice (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  isingm_pkg::t_read_req  i_rd,
    input  isingm_pkg::t_write_req i_wr,
    output isingm_pkg::t_row       o_row_up,
    output isingm_pkg::t_row       o_row_here,
    output isingm_pkg::t_row       o_row_down
);

    isingm_pkg::t_row r_mem_up   [isingm_pkg::LATTICE_SIDE];
    isingm_pkg::t_row r_mem_here [isingm_pkg::LATTICE_SIDE];
    isingm_pkg::t_row r_mem_down [isingm_pkg::LATTICE_SIDE];

    isingm_pkg::t_row r_rd_up;
    isingm_pkg::t_row r_rd_here;
    isingm_pkg::t_row r_rd_down;
    isingm_pkg::t_idx r_addr_up;
    isingm_pkg::t_idx r_addr_here;
    isingm_pkg::t_idx r_addr_down;

    logic [isingm_pkg::LATTICE_SIDE-1:0] r_row_valid;
    logic                                r_byp_valid;
    isingm_pkg::t_idx                    r_byp_row;
    isingm_pkg::t_row                    r_byp_data;

    // Memory copies: same write to all, one read port each.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_up[i_wr.row]   <= i_wr.data;
            r_mem_here[i_wr.row] <= i_wr.data;
            r_mem_down[i_wr.row] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_up     <= r_mem_up[i_rd.up];
            r_rd_here   <= r_mem_here[i_rd.here];
            r_rd_down   <= r_mem_down[i_rd.down];
            r_addr_up   <= i_rd.up;
            r_addr_here <= i_rd.here;
            r_addr_down <= i_rd.down;
        end
    end

    // Track written rows and hold the latest write for same-edge read collisions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_byp_valid <= 1'b0;
        end else if (i_wr.en) begin
            r_row_valid[i_wr.row] <= 1'b1;
            r_byp_valid           <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_byp_row  <= i_wr.row;
            r_byp_data <= i_wr.data;
        end
    end

    // Latest write wins; a row never written reads as all +1.
    function automatic isingm_pkg::t_row resolve(input isingm_pkg::t_idx a,
                                                 input isingm_pkg::t_row raw);
        isingm_pkg::t_row res;
        if (r_byp_valid && (r_byp_row == a)) begin
            res = r_byp_data;
        end else if (!r_row_valid[a]) begin
            res = '1;
        end else begin
            res = raw;
        end
        return res;
    endfunction

    assign o_row_up   = resolve(r_addr_up, r_rd_up);
    assign o_row_here = resolve(r_addr_here, r_rd_here);
    assign o_row_down = resolve(r_addr_down, r_rd_down);

endmodule

// File: rtl/core/ising_metropolis_spin_update.sv
// Top level of the Ising Metropolis spin update block: handshake, threshold registers, update.
// Pipeline: rows are read at the accepting edge, and the update lands in the output register
//   when stage 1 advances, which it does once that register is free or drained.
// Throughput: one item per cycle while results are taken; each of the three copies has one
//   read port, so the up, current and down rows of a site are read in the same cycle.
// Reset: synchronous, active low; clears pipeline valids, thresholds and per-row valid bits,
//   so the whole lattice reads as +1 right after reset with no clearing pass.
module ising_metropolis_spin_update (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [isingm_pkg::THRESH_W-1:0] i_cfg_data,
    isingm_item_if.sink               i_item,
    isingm_result_if.source           o_result
);

    // Threshold registers, to be written only while idle; the block itself does not enforce this.
    isingm_pkg::t_thresh r_accept_energy_four;
    isingm_pkg::t_thresh r_accept_energy_eight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_energy_four  <= '0;
            r_accept_energy_eight <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                isingm_pkg::CFG_ACCEPT_FOUR:  r_accept_energy_four  <= i_cfg_data;
                isingm_pkg::CFG_ACCEPT_EIGHT: r_accept_energy_eight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake. Stage 1 holds the item while its rows come out of the memories;
    // it advances into the output register whenever that register is free or drained.
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_accept;

    assign s1_adv        = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready  = !r_s1_valid || s1_adv;
    assign in_accept     = i_item.valid && i_item.ready;

    // Site addresses of the incoming item; reduce out-of-range indexes first.
    isingm_pkg::t_idx in_row;
    isingm_pkg::t_idx in_col;
    isingm_pkg::t_read_req rd_req;

    assign in_row      = isingm_pkg::reduce_index(i_item.row);
    assign in_col      = isingm_pkg::reduce_index(i_item.column);
    assign rd_req.en   = in_accept;
    assign rd_req.up   = isingm_pkg::wrap_dec(in_row);
    assign rd_req.here = in_row;
    assign rd_req.down = isingm_pkg::wrap_inc(in_row);

    // Stage 1 payload.
    logic [1:0]          r_s1_cmd;
    isingm_pkg::t_idx    r_s1_row;
    isingm_pkg::t_idx    r_s1_col;
    isingm_pkg::t_thresh r_s1_rnd;
    logic                r_s1_wval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd  <= i_item.command;
            r_s1_row  <= in_row;
            r_s1_col  <= in_col;
            r_s1_rnd  <= i_item.random_fraction;
            r_s1_wval <= i_item.spin_value;
        end
    end

    // Lattice storage; rows arrive in the cycle after the read request.
    isingm_pkg::t_row       row_up;
    isingm_pkg::t_row       row_here;
    isingm_pkg::t_row       row_down;
    isingm_pkg::t_write_req wr_req;

    isingm_lattice u_lattice (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (rd_req),
        .i_wr       (wr_req),
        .o_row_up   (row_up),
        .o_row_here (row_here),
        .o_row_down (row_down)
    );

    // Update logic. With k neighbors aligned with the site spin, E = 4k - 8.
    isingm_pkg::t_idx col_left;
    isingm_pkg::t_idx col_right;
    logic             spin_here;
    logic [2:0]       plus_count;
    logic [2:0]       aligned;
    logic [isingm_pkg::ENERGY_W-1:0] energy_calc;
    logic             flip_calc;
    logic             spin_new;
    logic             flipped_calc;
    logic [isingm_pkg::ENERGY_W-1:0] energy_out;
    logic             do_write;
    isingm_pkg::t_row row_new;

    assign col_left  = isingm_pkg::wrap_dec(r_s1_col);
    assign col_right = isingm_pkg::wrap_inc(r_s1_col);
    assign spin_here = row_here[r_s1_col];

    always_comb begin
        plus_count  = {2'b00, row_up[r_s1_col]} + {2'b00, row_down[r_s1_col]}
                    + {2'b00, row_here[col_left]} + {2'b00, row_here[col_right]};
        aligned     = spin_here ? plus_count : 3'd4 - plus_count;
        energy_calc = {aligned, 2'b00} - isingm_pkg::ENERGY_W'(8);
        priority if (aligned <= 3'd2) begin
            flip_calc = 1'b1;
        end else if (aligned == 3'd3) begin
            flip_calc = r_s1_rnd < r_accept_energy_four;
        end else begin
            flip_calc = r_s1_rnd < r_accept_energy_eight;
        end

        unique case (isingm_pkg::t_command'(r_s1_cmd))
            isingm_pkg::CMD_UPDATE: begin
                spin_new     = spin_here ^ flip_calc;
                flipped_calc = flip_calc;
                energy_out   = energy_calc;
                do_write     = flip_calc;
            end
            isingm_pkg::CMD_WRITE: begin
                spin_new     = r_s1_wval;
                flipped_calc = 1'b0;
                energy_out   = '0;
                do_write     = 1'b1;
            end
            default: begin
                // Read, and the unused code handled as a read.
                spin_new     = spin_here;
                flipped_calc = 1'b0;
                energy_out   = '0;
                do_write     = 1'b0;
            end
        endcase

        row_new           = row_here;
        row_new[r_s1_col] = spin_new;
    end

    // Write back the modified row as the item leaves stage 1.
    assign wr_req.en   = s1_adv && do_write;
    assign wr_req.row  = r_s1_row;
    assign wr_req.data = row_new;

    // Output register.
    logic                            r_out_spin;
    logic                            r_out_flipped;
    logic [isingm_pkg::ENERGY_W-1:0] r_out_energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_spin    <= spin_new;
            r_out_flipped <= flipped_calc;
            r_out_energy  <= energy_out;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.spin_after    = r_out_spin;
    assign o_result.flipped       = r_out_flipped;
    assign o_result.energy_change = $signed(r_out_energy);

    // A negative energy change always flips the spin.
    a_negative_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.energy_change[isingm_pkg::ENERGY_W-1]) |-> o_result.flipped)
        else $error("negative energy change without a flip");

    // Energy change takes only the five lattice values.
    a_energy_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.energy_change == -5'sd8 ||
                            o_result.energy_change == -5'sd4 ||
                            o_result.energy_change == 5'sd0 ||
                            o_result.energy_change == 5'sd4 ||
                            o_result.energy_change == 5'sd8))
        else $error("illegal energy change");

    // A stalled stage 1 keeps its item.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_row) && $stable(r_s1_col)))
        else $error("stage 1 item lost while stalled");

    // Lattice writes come only from an item leaving stage 1.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> (r_s1_valid && (!r_out_valid || o_result.ready)))
        else $error("lattice write without an advancing item");

endmodule

// File: test/ising_metropolis_spin_update_tb.sv
// Self-checking testbench for the Ising Metropolis spin update block.
`timescale 1ns / 1ps

module ising_metropolis_spin_update_tb;
    import isingm_pkg::*;

    // Codes that the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 260;

    typedef struct {
        logic                       spin_after;
        logic                       flipped;
        logic signed [ENERGY_W-1:0] energy_change;
    } spin_result_t;

    // Tracks the lattice and thresholds and holds the spin results still owed by the block.
    class spin_lattice_scoreboard;
        bit           lattice [LATTICE_SIDE][LATTICE_SIDE];
        t_thresh      accept_four;
        t_thresh      accept_eight;
        spin_result_t pending_results[$];
        int unsigned  mismatches;

        function new();
            foreach (lattice[r, c]) lattice[r][c] = 1'b1;
            accept_four  = '0;
            accept_eight = '0;
            mismatches   = 0;
        endfunction

        function void set_thresholds(t_thresh four, t_thresh eight);
            accept_four  = four;
            accept_eight = eight;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // Apply one accepted transaction to the lattice and queue the result it causes.
        function void note_item(logic [1:0] cmd, logic [FIELD_W-1:0] row_in,
                                logic [FIELD_W-1:0] col_in, t_thresh rnd, logic wval);
            int unsigned  r, c, north, south, west, east;
            int           plus_count, spin_sign, energy;
            bit           flip;
            spin_result_t res;
            r      = row_in % LATTICE_SIDE;
            c      = col_in % LATTICE_SIDE;
            flip   = 1'b0;
            energy = 0;
            if (cmd == CMD_UPDATE) begin
                north = (r + LATTICE_SIDE - 1) % LATTICE_SIDE;
                south = (r + 1) % LATTICE_SIDE;
                west  = (c + LATTICE_SIDE - 1) % LATTICE_SIDE;
                east  = (c + 1) % LATTICE_SIDE;
                plus_count = int'(lattice[north][c]) + int'(lattice[south][c])
                           + int'(lattice[r][west]) + int'(lattice[r][east]);
                spin_sign  = lattice[r][c] ? 1 : -1;
                energy     = 2 * spin_sign * (2 * plus_count - 4);
                if (energy <= 0) begin
                    flip = 1'b1;
                end else if (energy == 4) begin
                    flip = rnd < accept_four;
                end else begin
                    flip = rnd < accept_eight;
                end
                if (flip) lattice[r][c] = !lattice[r][c];
            end else if (cmd == CMD_WRITE) begin
                lattice[r][c] = wval;
            end
            // Reads and the unused code leave the lattice alone
            res.spin_after    = lattice[r][c];
            res.flipped       = flip;
            res.energy_change = energy[ENERGY_W-1:0];
            pending_results.push_back(res);
        endfunction

        function void check_result(logic spin, logic flip, logic signed [ENERGY_W-1:0] energy);
            spin_result_t want;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: spin %0b flip %0b energy %0d",
                                        spin, flip, energy));
                return;
            end
            want = pending_results.pop_front();
            if (spin !== want.spin_after || flip !== want.flipped
                    || energy !== want.energy_change) begin
                note_mismatch($sformatf({"expected spin %0b flip %0b energy %0d,",
                                         " got spin %0b flip %0b energy %0d"},
                                        want.spin_after, want.flipped, want.energy_change,
                                        spin, flip, energy));
            end
        endfunction

        function void flag_leftovers();
            if (pending_results.size() != 0)
                note_mismatch($sformatf("%0d expected results never arrived",
                                        pending_results.size()));
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    cfg_we;
    logic    cfg_index;
    t_thresh cfg_data;
    bit      idling_on;
    int      cycle_count = 0;

    isingm_item_if   item_ch ();
    isingm_result_if result_ch ();

    spin_lattice_scoreboard sb = new();

    ising_metropolis_spin_update dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Watchdog: end the run if the block hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: stall in random bursts while idling is on, otherwise stay ready.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    // Check every result transaction against the oldest pending expectation.
    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.spin_after, result_ch.flipped, result_ch.energy_change);
    end

    // Drive one item, optionally after an idle burst, and hold it until the block takes it.
    // Called at a rising edge; returns at the edge where the transaction happened.
    task automatic drive_item(input logic [1:0] cmd, input logic [FIELD_W-1:0] row,
                              input logic [FIELD_W-1:0] col, input t_thresh rnd,
                              input logic wval);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.command         <= cmd;
        item_ch.row             <= row;
        item_ch.column          <= col;
        item_ch.random_fraction <= rnd;
        item_ch.spin_value      <= wval;
        @(posedge clk);
        while (item_ch.ready !== 1'b1) @(posedge clk);
        sb.note_item(cmd, row, col, rnd, wval);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both thresholds on consecutive edges; only call while the block is idle.
    task automatic write_thresholds(input t_thresh four, input t_thresh eight);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACCEPT_FOUR;
        cfg_data  <= four;
        @(posedge clk);
        cfg_index <= CFG_ACCEPT_EIGHT;
        cfg_data  <= eight;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_thresholds(four, eight);
    endtask

    // Random traffic, mostly updates. Most sites fall in a small patch that straddles
    // the wrap-around corner so neighbors keep interacting; the rest roam the lattice.
    task automatic run_random_items(input int count);
        logic [1:0]         cmd;
        logic [FIELD_W-1:0] row, col;
        t_thresh            rnd;
        int unsigned        roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      cmd = CMD_UPDATE;
            else if (roll < 85) cmd = CMD_WRITE;
            else if (roll < 97) cmd = CMD_READ;
            else                cmd = CMD_UNUSED;
            if ($urandom_range(0, 3) != 0) row = FIELD_W'(62 + $urandom_range(0, 4));
            else                           row = FIELD_W'($urandom);
            if ($urandom_range(0, 3) != 0) col = FIELD_W'(62 + $urandom_range(0, 4));
            else                           col = FIELD_W'($urandom);
            // Aim some fractions right at a threshold to hit the strict compare
            case ($urandom_range(0, 3))
                0:       rnd = sb.accept_four + t_thresh'($urandom_range(0, 2)) - 1;
                1:       rnd = sb.accept_eight + t_thresh'($urandom_range(0, 2)) - 1;
                default: rnd = $urandom;
            endcase
            drive_item(cmd, row, col, rnd, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_ACCEPT_FOUR;
        cfg_data                = '0;
        idling_on               = 1'b0;
        item_ch.valid           = 1'b0;
        item_ch.command         = CMD_READ;
        item_ch.row             = '0;
        item_ch.column          = '0;
        item_ch.random_fraction = '0;
        item_ch.spin_value      = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, thresholds still at reset (zero): lattice starts all +1.
        drive_item(CMD_READ,   6'd0,  6'd0,  32'h0000_0000, 1'b0);
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'h0000_0000, 1'b0); // E=8, zero threshold
        drive_item(CMD_WRITE,  6'd0,  6'd0,  32'h0000_0000, 1'b0);
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'hFFFF_FFFF, 1'b0); // E=-8, always flips
        drive_item(CMD_WRITE,  6'd63, 6'd0,  32'h0000_0000, 1'b0); // north via wrap
        drive_item(CMD_WRITE,  6'd0,  6'd63, 32'h0000_0000, 1'b0); // west via wrap
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'hFFFF_FFFF, 1'b1); // E=0 flips
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'hFFFF_FFFF, 1'b1); // E=0 flips back
        drive_item(CMD_WRITE,  6'd1,  6'd0,  32'h0000_0000, 1'b0);
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'h0000_0000, 1'b0); // E=-4 flips
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'h0000_0000, 1'b0); // E=4, zero threshold
        drive_item(CMD_WRITE,  6'd0,  6'd1,  32'h0000_0000, 1'b0);
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'h0000_0000, 1'b0); // E=8, zero threshold
        drive_item(CMD_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1); // unused code acts as read
        drive_item(CMD_READ,   6'd63, 6'd0,  32'hFFFF_FFFF, 1'b1);
        drain_results();

        // Directed, thresholds at full scale: only the all-ones fraction fails to flip.
        write_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'hFFFF_FFFF, 1'b0); // E=8, not below
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'hFFFF_FFFE, 1'b0); // E=8 flips
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'hFFFF_FFFF, 1'b0); // E=-8 flips
        drive_item(CMD_WRITE,  6'd1,  6'd0,  32'h0000_0000, 1'b1);
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'hFFFF_FFFF, 1'b0); // E=4, not below
        drive_item(CMD_UPDATE, 6'd0,  6'd0,  32'hFFFF_FFFE, 1'b0); // E=4 flips

        // Random phases over several threshold settings
        idling_on = 1'b1;
        run_random_items(PHASE_ITEMS);
        drain_results();

        // Near the critical temperature
        write_thresholds(32'h2BF5_3A40, 32'h078C_2B10);
        run_random_items(PHASE_ITEMS);
        drain_results();

        // Back-to-back stretch with random thresholds
        idling_on = 1'b0;
        write_thresholds($urandom, $urandom);
        run_random_items(PHASE_ITEMS);
        drain_results();

        idling_on = 1'b1;
        write_thresholds(32'h8000_0000, 32'h0000_0000);
        run_random_items(PHASE_ITEMS);
        drain_results();

        write_thresholds(32'h0000_0000, 32'hFFFF_FFFF);
        run_random_items(PHASE_ITEMS);
        drain_results();

        // Final stretch: no idling on either side
        idling_on = 1'b0;
        write_thresholds($urandom, $urandom);
        run_random_items(PHASE_ITEMS);
        drain_results();

        sb.flag_leftovers();
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
